/* rtl/tea_pkg.sv */
package tea_pkg;

    // Cipher geometry: each round is split into two half-round stages.
    localparam int ROUNDS = 32;
    localparam int STAGES = 2 * ROUNDS;

    localparam logic [31:0] DELTA      = 32'h9e37_79b9;
    localparam logic [31:0] KEY0_RESET = 32'h2927_c18c;
    localparam logic [31:0] KEY1_RESET = 32'h75f8_c48f;
    localparam logic [31:0] KEY2_RESET = 32'h43fd_99f7;
    localparam logic [31:0] KEY3_RESET = 32'hff0f_7457;

    // Operation select carried with each block.
    localparam logic FUNC_ENCRYPT = 1'b0;
    localparam logic FUNC_DECRYPT = 1'b1;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } t_reg_idx;

    // The 128-bit key as four words.
    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } t_key;

    // Contents of one pipeline slot.
    typedef struct packed {
        logic        valid;
        logic        func;
        logic [31:0] lo;
        logic [31:0] hi;
    } t_stage;

    // TEA mixing function on one half.
    function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] s,
                                        input logic [31:0] ka, input logic [31:0] kb);
        return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

    // Running sum seen by half-round stage j when encrypting.
    function automatic logic [31:0] enc_sum(input int j);
        logic [63:0] p;
        p = 64'((j >> 1) + 1) * 64'(DELTA);
        return p[31:0];
    endfunction

    // Running sum seen by half-round stage j when decrypting.
    function automatic logic [31:0] dec_sum(input int j);
        logic [63:0] p;
        p = 64'(ROUNDS - (j >> 1)) * 64'(DELTA);
        return p[31:0];
    endfunction

endpackage

/* rtl/tea_regs.sv */
module tea_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tea_pkg::t_key       o_key
);

    tea_pkg::t_key    r_key;
    tea_pkg::t_key    n_key;
    tea_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = tea_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_key  = r_key;

    // Write decode for the four key words.
    always_comb begin
        n_key = r_key;
        if (w_wr) begin
            unique case (w_idx)
                tea_pkg::REG_KEY0: n_key.k0 = pwdata;
                tea_pkg::REG_KEY1: n_key.k1 = pwdata;
                tea_pkg::REG_KEY2: n_key.k2 = pwdata;
                tea_pkg::REG_KEY3: n_key.k3 = pwdata;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.k0 <= tea_pkg::KEY0_RESET;
            r_key.k1 <= tea_pkg::KEY1_RESET;
            r_key.k2 <= tea_pkg::KEY2_RESET;
            r_key.k3 <= tea_pkg::KEY3_RESET;
        end else begin
            r_key <= n_key;
        end
    end

    // Read back the addressed key word.
    always_comb begin
        unique case (w_idx)
            tea_pkg::REG_KEY0: prdata = r_key.k0;
            tea_pkg::REG_KEY1: prdata = r_key.k1;
            tea_pkg::REG_KEY2: prdata = r_key.k2;
            tea_pkg::REG_KEY3: prdata = r_key.k3;
        endcase
    end

endmodule

/* rtl/tea_stage.sv */
module tea_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_odd,
    input  logic [31:0]         i_sum_enc,
    input  logic [31:0]         i_sum_dec,
    input  tea_pkg::t_key       i_key,
    input  tea_pkg::t_stage     i_data,
    output tea_pkg::t_stage     o_data
);

    tea_pkg::t_stage r_data;
    tea_pkg::t_stage n_data;
    logic            w_upd_lo;
    logic [31:0]     w_src;
    logic [31:0]     w_dst;
    logic [31:0]     w_sum;
    logic [31:0]     w_ka;
    logic [31:0]     w_kb;
    logic [31:0]     w_mix;
    logic [31:0]     w_new;

    // Encryption updates the low half on even stages, decryption on odd ones.
    assign w_upd_lo = (i_data.func == i_odd);
    assign w_src    = w_upd_lo ? i_data.hi : i_data.lo;
    assign w_dst    = w_upd_lo ? i_data.lo : i_data.hi;
    assign w_ka     = w_upd_lo ? i_key.k0 : i_key.k2;
    assign w_kb     = w_upd_lo ? i_key.k1 : i_key.k3;
    assign w_sum    = (i_data.func == tea_pkg::FUNC_DECRYPT) ? i_sum_dec : i_sum_enc;
    assign w_mix    = tea_pkg::mix(w_src, w_sum, w_ka, w_kb);

    // Add when encrypting, subtract when decrypting.
    assign w_new = (i_data.func == tea_pkg::FUNC_DECRYPT) ? (w_dst - w_mix) : (w_dst + w_mix);

    always_comb begin
        n_data       = i_data;
        n_data.lo    = w_upd_lo ? w_new : i_data.lo;
        n_data.hi    = w_upd_lo ? i_data.hi : w_new;
    end

    // Valid bit is reset; the slot only loads when the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/tea_block_cipher.sv */
// TEA block cipher, 64-bit block and 128-bit key, fully pipelined. Each
// transaction on the input channel carries one block and a func bit (0
// encrypt, 1 decrypt); one result comes out once it has passed every stage,
// since each of the 32 rounds is split into two half-round register stages,
// one mix and one add per stage. While the pipeline is not held, a new block
// is taken every cycle. When the output is stalled while holding a result,
// the whole pipeline holds and the input stalls with it. The key lives in
// four 32-bit registers at byte addresses 0, 4, 8 and 12 of the APB port
// and should only be changed while no block is in flight.
module tea_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [31:0] i_block_low,
    input  logic [31:0] i_block_high,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_low,
    output logic [31:0] o_result_high,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tea_pkg::t_key   w_key;
    tea_pkg::t_stage w_pipe [0:tea_pkg::STAGES];
    logic            w_adv;

    // Key registers and APB access.
    tea_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (w_key)
    );

    // The pipeline moves unless a finished result is held by the output.
    assign w_adv      = !(w_pipe[tea_pkg::STAGES].valid && i_out_stall);
    assign o_in_stall = !w_adv;

    assign w_pipe[0].valid = i_in_valid;
    assign w_pipe[0].func  = i_func;
    assign w_pipe[0].lo    = i_block_low;
    assign w_pipe[0].hi    = i_block_high;

    // One half-round per stage, with the round sums fixed per stage.
    for (genvar j = 0; j < tea_pkg::STAGES; j++) begin : g_stage
        tea_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_adv),
            .i_odd     (1'(j % 2)),
            .i_sum_enc (tea_pkg::enc_sum(j)),
            .i_sum_dec (tea_pkg::dec_sum(j)),
            .i_key     (w_key),
            .i_data    (w_pipe[j]),
            .o_data    (w_pipe[j+1])
        );
    end

    assign o_out_valid   = w_pipe[tea_pkg::STAGES].valid;
    assign o_result_low  = w_pipe[tea_pkg::STAGES].lo;
    assign o_result_high = w_pipe[tea_pkg::STAGES].hi;

`ifndef SYNTHESIS
    // An accepted block shows up in the first stage on the next edge.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> w_pipe[1].valid)
        else $error("accepted block did not enter the pipeline");

    // A held result keeps its data while the pipeline is frozen.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_result_low) && $stable(o_result_high)))
        else $error("held result changed under stall");

    // The input only stalls while a result waits at the output.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a waiting result");

    // A frozen pipeline keeps the first stage unchanged.
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_pipe[1].valid))
        else $error("first stage moved while frozen");
`endif

endmodule
